// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, switched off while reset is asserted.
`define TSQM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// The condition must never be true at a clock edge outside reset.
`define TSQM_ASSERT_NEVER(label, clk, rst_n, cond) \
    `TSQM_ASSERT(label, clk, rst_n, !(cond))

`endif

// ----- rtl/core/tsqm_pkg.sv -----
`timescale 1ns / 1ps

package tsqm_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;

    localparam int VAL_W = 12;
    localparam int Z_W   = 13;
    localparam int PROD_W = 2 * VAL_W;

    localparam logic [VAL_W-1:0] FULL_SCALE   = 12'd4095;
    localparam logic [Z_W-1:0]   OPEN_LEVEL   = 13'd120;
    localparam logic [Z_W-1:0]   HOLD_LEVEL   = 13'd70;
    localparam logic [VAL_W-1:0] SPREAD_LIMIT = 12'd120;
    localparam int               MARGIN       = 24;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_FROM_RAW_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_FROM_RAW_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_RAW_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_RAW_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RAW_LOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RAW_HIGH   = 3'd6;

    localparam logic [VAL_W-1:0] X_RAW_LOW_RST  = 12'd1837;
    localparam logic [VAL_W-1:0] X_RAW_HIGH_RST = 12'd3559;
    localparam logic [VAL_W-1:0] Y_RAW_LOW_RST  = 12'd1590;
    localparam logic [VAL_W-1:0] Y_RAW_HIGH_RST = 12'd3477;

    typedef struct packed {
        logic [VAL_W-1:0] pressure_one;
        logic [VAL_W-1:0] pressure_two;
        logic [VAL_W-1:0] axis_a_0;
        logic [VAL_W-1:0] axis_a_1;
        logic [VAL_W-1:0] axis_a_2;
        logic [VAL_W-1:0] axis_a_3;
        logic [VAL_W-1:0] axis_a_4;
        logic [VAL_W-1:0] axis_b_0;
        logic [VAL_W-1:0] axis_b_1;
        logic [VAL_W-1:0] axis_b_2;
        logic [VAL_W-1:0] axis_b_3;
        logic [VAL_W-1:0] axis_b_4;
    } t_in_item;

    typedef struct packed {
        logic             touched;
        logic [VAL_W-1:0] x_position;
        logic [VAL_W-1:0] y_position;
        logic [Z_W-1:0]   pressure;
    } t_out_item;

    typedef logic [4:0][VAL_W-1:0] t_five;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] raw;
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
    } t_map_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] value;
    } t_map_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT,
        S_DECIDE,
        S_MAP,
        S_DONE
    } t_ctl_state;

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_DIV,
        M_FIN
    } t_map_state;

endpackage

// ----- rtl/core/tsqm_sort5.sv -----
`timescale 1ns / 1ps

// Five-entry odd-even transposition sorter, one round per step.
// Five rounds leave the entries in ascending order.
module tsqm_sort5 (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic                          i_step,
    input  tsqm_pkg::t_five               i_data,
    output logic [tsqm_pkg::VAL_W-1:0]    o_q1,
    output logic [tsqm_pkg::VAL_W-1:0]    o_q2,
    output logic [tsqm_pkg::VAL_W-1:0]    o_q3
);

    tsqm_pkg::t_five r_val;
    tsqm_pkg::t_five n_val;
    logic            r_phase;
    logic            n_phase;

    always_comb begin
        n_val   = r_val;
        n_phase = r_phase;
        if (i_load) begin
            n_val   = i_data;
            n_phase = 1'b0;
        end else if (i_step) begin
            for (int k = 0; k < 4; k++) begin
                if ((k % 2) == int'(r_phase) && r_val[k] > r_val[k+1]) begin
                    n_val[k]   = r_val[k+1];
                    n_val[k+1] = r_val[k];
                end
            end
            n_phase = ~r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_phase <= n_phase;
    end

    assign o_q1 = r_val[1];
    assign o_q2 = r_val[2];
    assign o_q3 = r_val[3];

endmodule

// ----- rtl/core/tsqm_map_unit.sv -----
`timescale 1ns / 1ps

// Maps one raw axis value to pixels: a shift-and-add multiplier takes one
// bit of the span per cycle, then a restoring divider produces one quotient
// bit per cycle in the same shift register. Sign and clamp are applied last.
module tsqm_map_unit #(
    parameter int SIZE = tsqm_pkg::SCREEN_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsqm_pkg::t_map_req i_req,
    output tsqm_pkg::t_map_rsp o_rsp
);

    localparam int VW = tsqm_pkg::VAL_W;
    localparam int PW = tsqm_pkg::PROD_W;
    localparam logic [VW-1:0] SPAN   = VW'(SIZE - 1 - 2 * tsqm_pkg::MARGIN);
    localparam logic [PW:0]   LAST   = (PW + 1)'(SIZE - 1);
    localparam logic [PW:0]   MARG_W = (PW + 1)'(tsqm_pkg::MARGIN);
    localparam logic [4:0]    MUL_LAST = 5'(VW - 1);
    localparam logic [4:0]    DIV_LAST = 5'(PW - 1);

    tsqm_pkg::t_map_state r_state;
    tsqm_pkg::t_map_state n_state;
    logic [4:0]    r_cnt;
    logic [VW-1:0] r_mcand;
    logic [VW-1:0] r_den;
    logic          r_neg;
    logic [VW-1:0] r_rem;
    logic [PW-1:0] r_pq;

    logic [VW:0]   diff;
    logic [VW:0]   span_den;
    logic [VW:0]   diff_neg;
    logic [VW:0]   den_neg;
    logic [VW:0]   mul_sum;
    logic [VW:0]   trial;
    logic [VW:0]   trial_sub;
    logic          trial_ge;
    logic [PW:0]   up_val;
    logic [PW:0]   down_val;

    assign diff     = {1'b0, i_req.raw} - {1'b0, i_req.lo};
    assign span_den = {1'b0, i_req.hi} - {1'b0, i_req.lo};
    assign diff_neg = -diff;
    assign den_neg  = -span_den;

    assign mul_sum   = {1'b0, r_pq[PW-1:VW]} + (r_pq[0] ? {1'b0, r_mcand} : '0);
    assign trial     = {r_rem, r_pq[PW-1]};
    assign trial_ge  = trial >= {1'b0, r_den};
    assign trial_sub = trial - {1'b0, r_den};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsqm_pkg::M_IDLE: if (i_req.start) n_state = tsqm_pkg::M_MUL;
            tsqm_pkg::M_MUL:  if (r_cnt == MUL_LAST) n_state = tsqm_pkg::M_DIV;
            tsqm_pkg::M_DIV:  if (r_cnt == DIV_LAST) n_state = tsqm_pkg::M_FIN;
            tsqm_pkg::M_FIN:  n_state = tsqm_pkg::M_IDLE;
            default:          n_state = tsqm_pkg::M_IDLE;
        endcase
    end

    // Result: 24 plus or minus the quotient, clamped to the screen.
    assign up_val   = {1'b0, r_pq} + MARG_W;
    assign down_val = MARG_W - {1'b0, r_pq};

    always_comb begin
        o_rsp.done = (r_state == tsqm_pkg::M_FIN);
        if (r_neg) begin
            o_rsp.value = ({1'b0, r_pq} > MARG_W) ? '0 : down_val[VW-1:0];
        end else begin
            o_rsp.value = (up_val > LAST) ? LAST[VW-1:0] : up_val[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsqm_pkg::M_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tsqm_pkg::M_IDLE: begin
                if (i_req.start) begin
                    r_mcand <= diff[VW] ? diff_neg[VW-1:0] : diff[VW-1:0];
                    r_den   <= span_den[VW] ? den_neg[VW-1:0] : span_den[VW-1:0];
                    r_neg   <= diff[VW] ^ span_den[VW];
                    r_rem   <= '0;
                    r_pq    <= {{VW{1'b0}}, SPAN};
                end
            end
            tsqm_pkg::M_MUL: begin
                r_pq <= {mul_sum, r_pq[VW-1:1]};
            end
            tsqm_pkg::M_DIV: begin
                r_rem <= trial_ge ? trial_sub[VW-1:0] : trial[VW-1:0];
                r_pq  <= {r_pq[PW-2:0], trial_ge};
            end
            tsqm_pkg::M_FIN: begin
                r_rem <= r_rem;
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

endmodule

// ----- rtl/core/touch_sample_qualify_and_map_top.sv -----
`timescale 1ns / 1ps

// Touch sample qualifier and screen mapper.
// The input channel (i_in_valid / o_in_ready / i_in_data) carries one
// converter burst per transfer: two pressure readings and five readings of
// each position channel. The output channel (o_out_valid / i_out_ready /
// o_out_data) returns exactly one result per burst: the touched flag, the
// x and y position and the pressure metric.
// A burst is sorted per axis in five rounds of a compare-exchange network.
// Bursts that report no contact, or that pass raw values through, go from the
// decide state straight to the done state. Calibrated bursts instead run two
// mapping units side by side, each a bit-serial multiplier followed by a
// restoring divider, and go to the done state when the units finish. One
// burst is in work at a time; the next is taken the cycle after the result
// is parked in the output register. Reset (synchronous, active low) closes
// the contact and loads the default calibration. While the receiver stalls,
// the result holds in the output register and the block still takes and
// works one more burst, then waits. Configuration writes take effect at
// once. The user must make them only while idle; the block itself does not
// enforce this.
module touch_sample_qualify_and_map_top #(
    parameter int SCREEN_WIDTH  = tsqm_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tsqm_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  tsqm_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output tsqm_pkg::t_out_item                o_out_data,
    input  logic                               i_cfg_we,
    input  logic [tsqm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tsqm_pkg::VAL_W-1:0]         i_cfg_data
);

`include "assert_macros.svh"

    localparam int VW = tsqm_pkg::VAL_W;
    localparam int ZW = tsqm_pkg::Z_W;
    localparam logic [2:0] SORT_LAST = 3'd4;

    // Configuration registers.
    logic          r_calibrated;
    logic          r_x_from_raw_x;
    logic          r_y_from_raw_x;
    logic [VW-1:0] r_x_raw_low;
    logic [VW-1:0] r_x_raw_high;
    logic [VW-1:0] r_y_raw_low;
    logic [VW-1:0] r_y_raw_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calibrated   <= 1'b1;
            r_x_from_raw_x <= 1'b1;
            r_y_from_raw_x <= 1'b0;
            r_x_raw_low    <= tsqm_pkg::X_RAW_LOW_RST;
            r_x_raw_high   <= tsqm_pkg::X_RAW_HIGH_RST;
            r_y_raw_low    <= tsqm_pkg::Y_RAW_LOW_RST;
            r_y_raw_high   <= tsqm_pkg::Y_RAW_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tsqm_pkg::CFG_CALIBRATED:   r_calibrated   <= i_cfg_data[0];
                tsqm_pkg::CFG_X_FROM_RAW_X: r_x_from_raw_x <= i_cfg_data[0];
                tsqm_pkg::CFG_Y_FROM_RAW_X: r_y_from_raw_x <= i_cfg_data[0];
                tsqm_pkg::CFG_X_RAW_LOW:    r_x_raw_low    <= i_cfg_data;
                tsqm_pkg::CFG_X_RAW_HIGH:   r_x_raw_high   <= i_cfg_data;
                tsqm_pkg::CFG_Y_RAW_LOW:    r_y_raw_low    <= i_cfg_data;
                tsqm_pkg::CFG_Y_RAW_HIGH:   r_y_raw_high   <= i_cfg_data;
                default:                    r_calibrated   <= r_calibrated;
            endcase
        end
    end

    // Control state and per-burst storage.
    tsqm_pkg::t_ctl_state r_state;
    tsqm_pkg::t_ctl_state n_state;
    logic [2:0]           r_sort_cnt;
    logic                 r_contact_open;
    logic                 n_contact_open;
    logic [VW-1:0]        r_held_x;
    logic [VW-1:0]        r_held_y;
    logic [ZW-1:0]        r_z;
    tsqm_pkg::t_out_item  r_res;
    tsqm_pkg::t_out_item  r_out;
    logic                 r_out_valid;

    logic                 in_xfer;
    logic                 out_load;
    logic                 sort_step;
    logic                 go_map;

    // Pressure: p1 + 4095 - p2, floored at zero.
    logic [ZW-1:0] z_sum;
    logic [ZW-1:0] z_val;
    assign z_sum = {1'b0, i_in_data.pressure_one} + {1'b0, tsqm_pkg::FULL_SCALE};
    assign z_val = (z_sum >= {1'b0, i_in_data.pressure_two}) ?
                   (z_sum - {1'b0, i_in_data.pressure_two}) : '0;

    // Per-axis sorters.
    logic [VW-1:0] a_q1, a_q2, a_q3;
    logic [VW-1:0] b_q1, b_q2, b_q3;

    tsqm_sort5 u_sort_a (
        .i_clk  (i_clk),
        .i_load (in_xfer),
        .i_step (sort_step),
        .i_data ({i_in_data.axis_a_4, i_in_data.axis_a_3, i_in_data.axis_a_2,
                  i_in_data.axis_a_1, i_in_data.axis_a_0}),
        .o_q1   (a_q1),
        .o_q2   (a_q2),
        .o_q3   (a_q3)
    );

    tsqm_sort5 u_sort_b (
        .i_clk  (i_clk),
        .i_load (in_xfer),
        .i_step (sort_step),
        .i_data ({i_in_data.axis_b_4, i_in_data.axis_b_3, i_in_data.axis_b_2,
                  i_in_data.axis_b_1, i_in_data.axis_b_0}),
        .o_q1   (b_q1),
        .o_q2   (b_q2),
        .o_q3   (b_q3)
    );

    // Qualification: hysteresis on pressure, spread check on both axes.
    logic [VW-1:0] a_spread;
    logic [VW-1:0] b_spread;
    logic          settled;
    logic          below;
    logic          touch_now;
    logic          pass_raw;
    logic [VW-1:0] new_x;
    logic [VW-1:0] new_y;

    assign a_spread  = a_q3 - a_q1;
    assign b_spread  = b_q3 - b_q1;
    assign settled   = (a_spread <= tsqm_pkg::SPREAD_LIMIT) &&
                       (b_spread <= tsqm_pkg::SPREAD_LIMIT);
    assign below     = r_z < (r_contact_open ? tsqm_pkg::HOLD_LEVEL
                                             : tsqm_pkg::OPEN_LEVEL);
    assign touch_now = !below && (settled || r_contact_open);
    assign pass_raw  = !r_calibrated || (r_x_raw_high == r_x_raw_low) ||
                       (r_y_raw_high == r_y_raw_low);
    assign new_x     = settled ? (tsqm_pkg::FULL_SCALE - b_q2) : r_held_x;
    assign new_y     = settled ? a_q2 : r_held_y;

    // Mapping units, one per screen axis, started together.
    tsqm_pkg::t_map_req map_x_req;
    tsqm_pkg::t_map_req map_y_req;
    tsqm_pkg::t_map_rsp map_x_rsp;
    tsqm_pkg::t_map_rsp map_y_rsp;

    always_comb begin
        map_x_req.start = go_map;
        map_x_req.raw   = r_x_from_raw_x ? new_x : new_y;
        map_x_req.lo    = r_x_raw_low;
        map_x_req.hi    = r_x_raw_high;
        map_y_req.start = go_map;
        map_y_req.raw   = r_y_from_raw_x ? new_x : new_y;
        map_y_req.lo    = r_y_raw_low;
        map_y_req.hi    = r_y_raw_high;
    end

    tsqm_map_unit #(.SIZE(SCREEN_WIDTH)) u_map_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_x_req),
        .o_rsp   (map_x_rsp)
    );

    tsqm_map_unit #(.SIZE(SCREEN_HEIGHT)) u_map_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_y_req),
        .o_rsp   (map_y_rsp)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsqm_pkg::S_IDLE:   if (in_xfer) n_state = tsqm_pkg::S_SORT;
            tsqm_pkg::S_SORT:   if (r_sort_cnt == SORT_LAST) n_state = tsqm_pkg::S_DECIDE;
            tsqm_pkg::S_DECIDE: n_state = (touch_now && !pass_raw) ? tsqm_pkg::S_MAP
                                                                   : tsqm_pkg::S_DONE;
            tsqm_pkg::S_MAP:    if (map_x_rsp.done) n_state = tsqm_pkg::S_DONE;
            tsqm_pkg::S_DONE:   if (out_load) n_state = tsqm_pkg::S_IDLE;
            default:            n_state = tsqm_pkg::S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_in_ready = (r_state == tsqm_pkg::S_IDLE);
        sort_step  = (r_state == tsqm_pkg::S_SORT);
        go_map     = (r_state == tsqm_pkg::S_DECIDE) && touch_now && !pass_raw;
        out_load   = (r_state == tsqm_pkg::S_DONE) && (!r_out_valid || i_out_ready);
    end

    assign in_xfer = i_in_valid && o_in_ready;

    always_comb begin
        n_contact_open = r_contact_open;
        if (r_state == tsqm_pkg::S_DECIDE) begin
            n_contact_open = touch_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= tsqm_pkg::S_IDLE;
            r_sort_cnt     <= '0;
            r_contact_open <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_contact_open <= n_contact_open;
            if (in_xfer) begin
                r_sort_cnt <= '0;
            end else if (sort_step) begin
                r_sort_cnt <= r_sort_cnt + 3'd1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_z <= z_val;
        end
        if (r_state == tsqm_pkg::S_DECIDE) begin
            if (touch_now) begin
                r_held_x <= new_x;
                r_held_y <= new_y;
            end
            r_res.touched    <= touch_now;
            r_res.pressure   <= r_z;
            r_res.x_position <= touch_now ? new_x : '0;
            r_res.y_position <= touch_now ? new_y : '0;
        end
        if (r_state == tsqm_pkg::S_MAP && map_x_rsp.done) begin
            r_res.x_position <= map_x_rsp.value;
            r_res.y_position <= map_y_rsp.value;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Both mapping units run the same schedule and must finish together.
    `TSQM_ASSERT(a_map_done_align, i_clk, i_rst_n, map_x_rsp.done == map_y_rsp.done)

    // A result without contact reports no position.
    `TSQM_ASSERT_NEVER(a_idle_pos_zero, i_clk, i_rst_n,
        o_out_valid && !o_out_data.touched &&
        (o_out_data.x_position != '0 || o_out_data.y_position != '0))

    // Pressure below the hold level always closes the contact.
    `TSQM_ASSERT(a_contact_close, i_clk, i_rst_n,
        (r_state == tsqm_pkg::S_DECIDE && r_z < tsqm_pkg::HOLD_LEVEL) |=> !r_contact_open)

endmodule
